// ===== src/ilid_pkg.sv =====
// Shared types and command codes for the indexed list insert/delete block.
package ilid_pkg;

	localparam logic [2:0] CMD_READ    = 3'd0;
	localparam logic [2:0] CMD_INS_HEAD = 3'd1;
	localparam logic [2:0] CMD_INS_TAIL = 3'd2;
	localparam logic [2:0] CMD_INS_POS  = 3'd3;
	localparam logic [2:0] CMD_DELETE  = 3'd4;

	localparam int POS_W = 10;
	localparam int LEN_W = 9;
	localparam int VAL_W = 32;

	typedef struct packed {
		logic [2:0]              cmd;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    hit;
		logic                    accepted;
		logic                    full_reject;
		logic [LEN_W-1:0]        length_now;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_issue;
		logic shift_init;
		logic shift_step;
		logic val_wr;
		logic fin;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic do_read;
		logic ins_ok;
		logic del_ok;
		logic shift_needed;
		logic shift_last;
	} stat_t;

endpackage

// ===== src/ilid_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ilid_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ilid_dp.sv =====
// Datapath: command latch, count, shift cursor, entry RAM and result register.
module ilid_dp #(
	parameter int CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ilid_pkg::req_t req,
	input  ilid_pkg::ctl_t ctl,
	output ilid_pkg::stat_t stat,
	output ilid_pkg::rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
	localparam int VW = ilid_pkg::VAL_W;
	localparam int LW = ilid_pkg::LEN_W;

	logic [2:0]    cmd_q;
	logic [PW-1:0] ep_q;
	logic [VW-1:0] val_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] cur_q;
	logic          mv_v_s1;
	logic [AW-1:0] mv_addr_s1;
	ilid_pkg::rsp_t rsp_q;

	logic [PW-1:0] count_x;
	logic [PW-1:0] ep_p1;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] count_nxt;
	logic [PW-1:0] count_nxt_x;
	logic [AW-1:0] ep_addr;
	logic          is_ins;
	logic          is_full;
	logic          ep_le;
	logic          ep_lt;
	logic          hit;
	logic          ins_ok;
	logic          del_ok;
	logic          rej;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;
	logic [PW-1:0] pos_x;

	assign count_x = PW'(count_q);
	assign ep_p1   = ep_q + PW'(1);
	assign cnt_m1  = count_q - CW'(1);
	assign ep_addr = ep_q[AW-1:0];
	assign pos_x   = PW'(req.position);

	assign is_ins  = (cmd_q == ilid_pkg::CMD_INS_HEAD) || (cmd_q == ilid_pkg::CMD_INS_TAIL) ||
	                 (cmd_q == ilid_pkg::CMD_INS_POS);
	assign is_full = (count_q == CW'(CAPACITY));
	assign ep_le   = (ep_q <= count_x);
	assign ep_lt   = (ep_q < count_x);
	assign hit     = (cmd_q == ilid_pkg::CMD_READ) && ep_lt;
	assign ins_ok  = is_ins && !is_full && ep_le;
	assign rej     = is_ins && is_full;
	assign del_ok  = (cmd_q == ilid_pkg::CMD_DELETE) && ep_lt;

	always_comb begin
		stat.do_read      = hit;
		stat.ins_ok       = ins_ok;
		stat.del_ok       = del_ok;
		stat.shift_needed = ins_ok ? ep_lt : (ep_p1 < count_x);
		stat.shift_last   = is_ins ? (cur_q == ep_addr) : (cur_q == cnt_m1[AW-1:0]);
	end

	always_comb begin
		if (ins_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (del_ok) begin
			count_nxt = cnt_m1;
		end else begin
			count_nxt = count_q;
		end
	end
	assign count_nxt_x = PW'(count_nxt);

	// Pending move write has priority; value write never overlaps it.
	assign ram_we    = mv_v_s1 || ctl.val_wr;
	assign ram_waddr = mv_v_s1 ? mv_addr_s1 : ep_addr;
	assign ram_wdata = mv_v_s1 ? ram_rdata : val_q;
	assign ram_re    = ctl.rd_issue || ctl.shift_step;
	assign ram_raddr = ctl.rd_issue ? ep_addr : cur_q;

	ilid_ram #(
		.W     (VW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mv_v_s1 <= 1'b0;
		end else begin
			mv_v_s1 <= ctl.shift_step;
			if (ctl.fin) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.cmd;
			val_q <= req.item_value;
			case (req.cmd)
				ilid_pkg::CMD_INS_HEAD: ep_q <= '0;
				ilid_pkg::CMD_INS_TAIL: ep_q <= count_x;
				default:                ep_q <= pos_x;
			endcase
		end
		if (ctl.shift_init) begin
			cur_q <= is_ins ? cnt_m1[AW-1:0] : ep_p1[AW-1:0];
		end else if (ctl.shift_step) begin
			cur_q <= is_ins ? (cur_q - AW'(1)) : (cur_q + AW'(1));
		end
		if (ctl.shift_step) begin
			mv_addr_s1 <= is_ins ? (cur_q + AW'(1)) : (cur_q - AW'(1));
		end
		if (ctl.fin) begin
			if (hit) begin
				rsp_q.read_value <= ram_rdata;
			end else if (cmd_q == ilid_pkg::CMD_READ) begin
				rsp_q.read_value <= '1;
			end else begin
				rsp_q.read_value <= '0;
			end
			rsp_q.hit         <= hit;
			rsp_q.accepted    <= hit || ins_ok || del_ok;
			rsp_q.full_reject <= rej;
			rsp_q.length_now  <= count_nxt_x[LW-1:0];
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count exceeds capacity");

	a_wport_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mv_v_s1 && ctl.val_wr))
		else $error("move write and value write collide");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fin && ins_ok) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow count");

	a_shift_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_step |-> (ins_ok || del_ok))
		else $error("shift step without a valid insert or delete");

endmodule

// ===== src/ilid_ctrl.sv =====
// Controller: sequences read, shift, value write and result hand-off.
module ilid_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  ilid_pkg::stat_t stat,
	output ilid_pkg::ctl_t  ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_WAIT,
		S_SHIFT,
		S_DRAIN,
		S_WR_VAL,
		S_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	always_comb begin
		ctl            = '0;
		ctl.load       = (state_q == S_IDLE) && cmd_valid;
		ctl.rd_issue   = (state_q == S_DECODE) && stat.do_read;
		ctl.shift_init = (state_q == S_DECODE) && (stat.ins_ok || stat.del_ok) &&
		                 stat.shift_needed;
		ctl.shift_step = (state_q == S_SHIFT);
		ctl.val_wr     = (state_q == S_WR_VAL);
		ctl.fin        = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (stat.do_read) begin
						state_q <= S_RD_WAIT;
					end else if (stat.ins_ok) begin
						state_q <= stat.shift_needed ? S_SHIFT : S_WR_VAL;
					end else if (stat.del_ok && stat.shift_needed) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RD_WAIT: state_q <= S_FIN;
				S_SHIFT: begin
					if (stat.shift_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= stat.ins_ok ? S_WR_VAL : S_FIN;
				S_WR_VAL: state_q <= S_FIN;
				S_FIN: begin
					// hold until the result register is free
					if (ctl.fin) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> rsp_valid_q)
		else $error("finished transaction not presented");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (state_q == S_DECODE))
		else $error("loaded transaction not decoded");

endmodule

// ===== src/indexed_list_insert_delete.sv =====
// Top level of the indexed list store: bounded shifting sequence of signed words.
//
// cmd channel (cmd_valid/cmd_ready/cmd_data) takes one command per transaction:
// read, insert at head, insert at tail, insert at position, delete at position.
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns one result per command, in
// order: read value (-1 on a miss), hit, accepted, full reject and the new length.
// Sequence: a command is taken in S_IDLE and decoded in S_DECODE. A read hit
// issues the RAM read and waits in S_RD_WAIT; an insert or delete with entries
// to move walks them in S_SHIFT and lets the last move write in S_DRAIN; an
// accepted insert then writes its value in S_WR_VAL. Every command ends in
// S_FIN, which loads the result register. The shift moves one entry per cycle
// through the RAM's single read and single write port.
// Throughput: one command in work at a time; cmd_ready returns the cycle after
// the result is loaded.
// Reset: arst_n clears the length; RAM contents are not cleared and are never
// read before written.
// Stall: a result waits in the output register while rsp_ready is low; the next
// command is still accepted and worked, then holds in its last state until the
// register frees.
module indexed_list_insert_delete #(
	parameter int CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ilid_pkg::req_t cmd_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ilid_pkg::rsp_t rsp_data
);

	ilid_pkg::ctl_t  ctl;
	ilid_pkg::stat_t stat;

	ilid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	ilid_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_data),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp_data)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the indexed list insert/delete block.
module testbench;

	localparam int CAPACITY    = 256;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYC  = 300;
	localparam int REPORT_MAX  = 10;
	localparam int POS_W       = ilid_pkg::POS_W;
	localparam int LEN_W       = ilid_pkg::LEN_W;
	localparam int VAL_W       = ilid_pkg::VAL_W;
	// codes above the delete command are not defined
	localparam logic [2:0] CMD_UNDEF_FIRST = ilid_pkg::CMD_DELETE + 3'd1;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	ilid_pkg::req_t cmd_data;
	logic rsp_valid;
	logic rsp_ready;
	ilid_pkg::rsp_t rsp_data;

	logic signed [VAL_W-1:0] shadow_list [0:CAPACITY-1];
	int   shadow_len = 0;
	ilid_pkg::rsp_t pending_results [$];
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	bit   burst_mode = 1'b0;

	indexed_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data (cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	always #1 clk = ~clk;

	// Apply one command to the shadow list and return the result it should give.
	function automatic ilid_pkg::rsp_t apply_list_cmd(ilid_pkg::req_t r);
		ilid_pkg::rsp_t res;
		int   p;
		res = '0;
		case (r.cmd)
			ilid_pkg::CMD_READ: begin
				if (r.position < shadow_len) begin
					res.read_value = shadow_list[r.position];
					res.hit        = 1'b1;
					res.accepted   = 1'b1;
				end else begin
					res.read_value = -1;
				end
			end
			ilid_pkg::CMD_INS_HEAD, ilid_pkg::CMD_INS_TAIL, ilid_pkg::CMD_INS_POS: begin
				if (shadow_len >= CAPACITY) begin
					res.full_reject = 1'b1;
				end else begin
					p = (r.cmd == ilid_pkg::CMD_INS_HEAD) ? 0 :
					    (r.cmd == ilid_pkg::CMD_INS_TAIL) ? shadow_len : int'(r.position);
					if (p <= shadow_len) begin
						for (int i = shadow_len; i > p; i--)
							shadow_list[i] = shadow_list[i-1];
						shadow_list[p] = r.item_value;
						shadow_len++;
						res.accepted = 1'b1;
					end
				end
			end
			ilid_pkg::CMD_DELETE: begin
				if (r.position < shadow_len) begin
					for (int i = r.position; i < shadow_len - 1; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
					res.accepted = 1'b1;
				end
			end
			default: ;
		endcase
		res.length_now = LEN_W'(shadow_len);
		return res;
	endfunction

	function automatic int draw_wait();
		if (burst_mode)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// Mostly in-range positions, some just past the end, a few anywhere.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return POS_W'($urandom_range(0, shadow_len));
		if (r < 9)
			return POS_W'($urandom_range(0, shadow_len + 3));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	task automatic send_command(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		ilid_pkg::req_t r;
		int   gap;
		r.cmd        = op;
		r.position   = pos;
		r.item_value = val;
		gap = draw_wait();
		repeat (gap) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_data  <= r;
		do @(posedge clk); while (cmd_ready !== 1'b1);
		pending_results.push_back(apply_list_cmd(r));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_command(ilid_pkg::CMD_READ, '0, 32'sd7);
		send_command(ilid_pkg::CMD_DELETE, '0, '0);
		send_command(ilid_pkg::CMD_INS_POS, 10'd1, 32'sd99);
		send_command(ilid_pkg::CMD_INS_POS, '0, 32'sh7FFF_FFFF);
		send_command(ilid_pkg::CMD_INS_HEAD, '1, 32'sh8000_0000);
		send_command(ilid_pkg::CMD_INS_TAIL, '1, -32'sd1);
		send_command(ilid_pkg::CMD_INS_POS, 10'd3, 32'sd0);
		send_command(ilid_pkg::CMD_INS_POS, 10'd2, 32'sd12345);
		send_command(ilid_pkg::CMD_INS_POS, '1, 32'sd55);
		for (int i = 0; i < 5; i++)
			send_command(ilid_pkg::CMD_READ, POS_W'(i), '1);
		send_command(ilid_pkg::CMD_READ, 10'd5, '0);
		send_command(ilid_pkg::CMD_READ, '1, '0);
		for (int i = 0; i < 3; i++)
			send_command(CMD_UNDEF_FIRST + 3'(i), POS_W'($urandom), $urandom);
		send_command(ilid_pkg::CMD_DELETE, '1, '0);
		send_command(ilid_pkg::CMD_DELETE, '0, '0);
		send_command(ilid_pkg::CMD_DELETE, POS_W'(shadow_len - 1), '0);
		send_command(ilid_pkg::CMD_DELETE, 10'd1, '0);
		send_command(ilid_pkg::CMD_READ, 10'd0, '0);
		send_command(ilid_pkg::CMD_READ, 10'd1, '0);
	endtask

	task automatic test_full_store();
		logic [2:0] op;
		while (shadow_len < CAPACITY) begin
			case ($urandom_range(0, 2))
				0:       op = ilid_pkg::CMD_INS_HEAD;
				1:       op = ilid_pkg::CMD_INS_TAIL;
				default: op = ilid_pkg::CMD_INS_POS;
			endcase
			send_command(op, POS_W'($urandom_range(0, shadow_len)), $urandom);
		end
		// full check comes before the position check
		send_command(ilid_pkg::CMD_INS_HEAD, '0, $urandom);
		send_command(ilid_pkg::CMD_INS_TAIL, '0, $urandom);
		send_command(ilid_pkg::CMD_INS_POS, '0, $urandom);
		send_command(ilid_pkg::CMD_INS_POS, '1, $urandom);
		send_command(ilid_pkg::CMD_READ, POS_W'(CAPACITY - 1), '0);
		send_command(ilid_pkg::CMD_READ, POS_W'(CAPACITY), '0);
		send_command(ilid_pkg::CMD_DELETE, POS_W'(CAPACITY - 1), '0);
		send_command(ilid_pkg::CMD_INS_POS, POS_W'(CAPACITY - 1), $urandom);
		send_command(ilid_pkg::CMD_DELETE, '0, '0);
	endtask

	task automatic test_random_mix(input int items, input int ins_pct, input int del_pct,
			input bit burst);
		int         r;
		logic [2:0] op;
		burst_mode = burst;
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				op = CMD_UNDEF_FIRST + 3'($urandom_range(0, 2));
			end else if (r < 4 + ins_pct) begin
				case ($urandom_range(0, 3))
					0:       op = ilid_pkg::CMD_INS_HEAD;
					1:       op = ilid_pkg::CMD_INS_TAIL;
					default: op = ilid_pkg::CMD_INS_POS;
				endcase
			end else if (r < 4 + ins_pct + del_pct) begin
				op = ilid_pkg::CMD_DELETE;
			end else begin
				op = ilid_pkg::CMD_READ;
			end
			send_command(op, pick_position(), $urandom);
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_drain_pause();
		wait_for_results();
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_store();
		test_random_mix(140, 20, 55, 1'b0);
		test_random_mix(140, 15, 70, 1'b1);
		test_random_mix(140, 60, 15, 1'b0);
		test_drain_pause();
		test_random_mix(140, 30, 30, 1'b0);
		test_random_mix(140, 70, 10, 1'b0);
		test_random_mix(140, 10, 70, 1'b0);

		wait_for_results();
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : rsp_sink
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait();
			repeat (stall) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		ilid_pkg::rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected transaction on rsp: %p", rsp_data);
			end else begin
				want = pending_results.pop_front();
				if (rsp_data.read_value !== want.read_value || rsp_data.hit !== want.hit ||
				    rsp_data.accepted !== want.accepted ||
				    rsp_data.full_reject !== want.full_reject ||
				    rsp_data.length_now !== want.length_now) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("rsp mismatch: want %0d/%b/%b/%b/%0d got %0d/%b/%b/%b/%0d",
							want.read_value, want.hit, want.accepted, want.full_reject,
							want.length_now, rsp_data.read_value, rsp_data.hit,
							rsp_data.accepted, rsp_data.full_reject, rsp_data.length_now);
				end
			end
		end
	end

	// End the run when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((cmd_valid === 1'b1 && cmd_ready === 1'b1) ||
		    (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (arst_n === 1'b1) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
src/ilid_pkg.sv
src/ilid_ram.sv
src/ilid_dp.sv
src/ilid_ctrl.sv
src/indexed_list_insert_delete.sv
tb/testbench.sv
